// ----- rtl/core/gkcg_pkg.sv -----
// ----------------------------------------------------------------------------
// gkcg_pkg
// Shared types and constants for the gaussian kernel coefficient generator.
// ----------------------------------------------------------------------------
package gkcg_pkg;

    localparam int MAX_TAPS       = 63;
    localparam int COEF_FRAC_BITS = 16;
    localparam int TAP_W          = 6;
    localparam int WEIGHT_W       = 17;
    localparam int TOTAL_W        = 23;
    localparam int COEF_W         = 17;
    localparam int SIGMA_W        = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
    localparam logic [COEF_W-1:0]   COEF_MAX    = 17'h1FFFF;
    localparam logic [19:0]         EXP_CUTOFF  = 20'hC0000;

    // reciprocals for the series term divides, exact for 32-bit dividends
    localparam logic [31:0] RECIP_DIV3 = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_DIV5 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [TAP_W-1:0]   tap_count;
        logic [SIGMA_W-1:0] sigma;
    } in_item_t;

    typedef struct packed {
        logic [TAP_W-1:0]  tap_index;
        logic [COEF_W-1:0] coefficient;
        logic              last_tap;
    } out_item_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TAP_START,
        OP_COEF_START,
        OP_CLEAR_TOTAL
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [TAP_W-1:0] tap;
        logic             zero_tap;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

endpackage

// ----- rtl/core/gaussian_kernel_coefficient_generator.sv -----
// ----------------------------------------------------------------------------
// gaussian_kernel_coefficient_generator
// Normalized 1-D gaussian kernel coefficients, one transaction per tap.
// ----------------------------------------------------------------------------
// channel  dir  ports               payload
// s_       in   s_valid/s_ready     tap_count, sigma
// m_       out  m_valid/m_ready     tap_index, coefficient, last_tap
//
// weight pass: 64-step exponent divide, 5-term series, 8 squarings per tap;
//   series and squarings skipped at a zero argument (center) or past the cutoff,
//   divide skipped for an even trailing tap; coefficient pass: 64-step normalizing
//   divide per tap plus the output wait, and accept and total clear per request
// reset: synchronous active-low aresetn clears the sequencers and the total
// one request at a time; m_ready low simply holds the current tap
// ----------------------------------------------------------------------------
module gaussian_kernel_coefficient_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gkcg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gkcg_pkg::out_item_t m_data
);

    gkcg_pkg::dp_cmd_t    cmd;
    gkcg_pkg::dp_status_t status;
    logic [gkcg_pkg::COEF_W-1:0] coef;

    gkcg_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .item    (s_data),
        .status  (status),
        .coef    (coef)
    );

    gkcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status),
        .coef    (coef)
    );

endmodule

// ----- rtl/core/gkcg_ram.sv -----
// ----------------------------------------------------------------------------
// gkcg_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gkcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/gkcg_datapath.sv -----
// ----------------------------------------------------------------------------
// gkcg_datapath
// Sequential arithmetic: exponent argument divide, polynomial exp, squaring
// chain, and the per-tap normalizing divide. Commands are taken only while idle.
// ----------------------------------------------------------------------------
module gkcg_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gkcg_pkg::dp_cmd_t      cmd,
    input  gkcg_pkg::in_item_t     item,
    output gkcg_pkg::dp_status_t   status,
    output logic [gkcg_pkg::COEF_W-1:0] coef
);

    localparam int TAPW_L = gkcg_pkg::TAP_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADIV, S_ACHK, S_TMUL, S_TDIV, S_SQR, S_WRND, S_WR,
        S_CRD, S_CWAIT, S_CDIV, S_CSAT
    } dp_state_t;

    dp_state_t state_reg;
    logic [15:0] sigma_reg;
    logic [31:0] s2_reg;
    logic [TAPW_L-1:0] reach_reg;
    logic [TAPW_L-1:0] tap_reg;
    logic        zero_reg;

    // shared restoring divider
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] dvsr_reg;

    logic [63:0] y_reg, e_reg, t_reg;
    logic [2:0]  k_reg;
    logic [3:0]  sq_reg;
    logic [127:0] prod_reg;
    logic        ph_reg;
    logic [gkcg_pkg::WEIGHT_W-1:0] w_reg;
    logic [gkcg_pkg::TOTAL_W-1:0]  total_reg;
    logic [gkcg_pkg::COEF_W-1:0]   coef_reg;

    logic                           ram_we;
    logic [gkcg_pkg::WEIGHT_W-1:0]  ram_q;

    logic [64:0] rem_shift;
    logic [64:0] rem_sub;
    logic [TAPW_L-1:0] tap_offset;
    logic [31:0] recip_k;
    logic [63:0] term_q;

    assign rem_shift = {rem_reg, quo_reg[63]};
    assign rem_sub   = rem_shift - {33'd0, dvsr_reg};
    assign tap_offset = (tap_reg >= reach_reg) ? tap_reg - reach_reg : reach_reg - tap_reg;
    assign ram_we    = (state_reg == S_WR);
    assign status.busy = (state_reg != S_IDLE);
    assign coef = coef_reg;

    // term divide by k: shifts for powers of two, reciprocal multiply otherwise
    always_comb begin
        unique case (k_reg)
            3'd3:    recip_k = gkcg_pkg::RECIP_DIV3;
            3'd5:    recip_k = gkcg_pkg::RECIP_DIV5;
            default: recip_k = 32'd0;
        endcase
    end

    always_comb begin
        unique case (k_reg)
            3'd2:    term_q = quo_reg >> 1;
            3'd3:    term_q = 64'(prod_reg >> 33);
            3'd4:    term_q = quo_reg >> 2;
            3'd5:    term_q = 64'(prod_reg >> 34);
            default: term_q = quo_reg;
        endcase
    end

    gkcg_ram #(.WIDTH(gkcg_pkg::WEIGHT_W), .DEPTH(gkcg_pkg::MAX_TAPS)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tap_reg),
        .wr_data (w_reg),
        .rd_addr (tap_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    unique case (cmd.op)
                        gkcg_pkg::OP_LOAD: begin
                            sigma_reg <= (item.sigma == '0) ? 16'd1 : item.sigma;
                            reach_reg <= cmd.tap;
                        end
                        gkcg_pkg::OP_CLEAR_TOTAL: total_reg <= '0;
                        gkcg_pkg::OP_TAP_START: begin
                            tap_reg  <= cmd.tap;
                            zero_reg <= cmd.zero_tap;
                            s2_reg   <= 32'(sigma_reg) * 32'(sigma_reg);
                            ph_reg   <= 1'b0;
                            state_reg <= S_ADIV;
                        end
                        gkcg_pkg::OP_COEF_START: begin
                            tap_reg   <= cmd.tap;
                            state_reg <= S_CRD;
                        end
                        default: ;
                    endcase
                end
                S_ADIV: begin
                    // setup then 64 restoring steps of d^2<<31 / s^2
                    if (!ph_reg) begin
                        quo_reg  <= {21'd0, 12'(tap_offset) * 12'(tap_offset), 31'd0};
                        rem_reg  <= '0;
                        dvsr_reg <= s2_reg;
                        cnt_reg  <= 7'd64;
                        ph_reg   <= 1'b1;
                        if (zero_reg) begin
                            w_reg <= '0;
                            state_reg <= S_WR;
                        end
                    end else if (cnt_reg != 0) begin
                        cnt_reg <= cnt_reg - 7'd1;
                        if (!rem_sub[64]) begin
                            rem_reg <= rem_sub[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                    end else begin
                        state_reg <= S_ACHK;
                    end
                end
                S_ACHK: begin
                    if (quo_reg == 64'd0) begin
                        w_reg <= gkcg_pkg::WEIGHT_ONE;
                        state_reg <= S_WR;
                    end else if (quo_reg >= 64'(gkcg_pkg::EXP_CUTOFF)) begin
                        w_reg <= '0;
                        state_reg <= S_WR;
                    end else begin
                        y_reg <= {quo_reg[55:0], 8'd0};
                        e_reg <= 64'h1_0000_0000;
                        t_reg <= 64'h1_0000_0000;
                        k_reg <= 3'd1;
                        ph_reg <= 1'b0;
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (!ph_reg) begin
                        prod_reg <= 128'(t_reg[32:0] * y_reg[31:0]);
                        ph_reg <= 1'b1;
                    end else begin
                        quo_reg  <= {32'd0, prod_reg[63:32]};
                        ph_reg   <= 1'b0;
                        state_reg <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (!ph_reg) begin
                        prod_reg <= 128'(quo_reg[31:0] * recip_k);
                        ph_reg <= 1'b1;
                    end else begin
                        t_reg <= term_q;
                        e_reg <= k_reg[0] ? e_reg - term_q : e_reg + term_q;
                        ph_reg <= 1'b0;
                        if (k_reg == 3'd5) begin
                            sq_reg <= 4'd0;
                            state_reg <= S_SQR;
                        end else begin
                            k_reg <= k_reg + 3'd1;
                            state_reg <= S_TMUL;
                        end
                    end
                end
                S_SQR: begin
                    if (!ph_reg) begin
                        prod_reg <= 128'(e_reg[32:0] * e_reg[32:0]);
                        ph_reg <= 1'b1;
                    end else begin
                        e_reg <= 64'((prod_reg + 128'h8000_0000) >> 32);
                        ph_reg <= 1'b0;
                        if (sq_reg == 4'd7) begin
                            state_reg <= S_WRND;
                        end else begin
                            sq_reg <= sq_reg + 4'd1;
                        end
                    end
                end
                S_WRND: begin
                    w_reg <= 17'((e_reg + 64'd32768) >> 16);
                    state_reg <= S_WR;
                end
                S_WR: begin
                    total_reg <= total_reg + 23'(w_reg);
                    state_reg <= S_IDLE;
                end
                S_CRD: state_reg <= S_CWAIT;
                S_CWAIT: begin
                    quo_reg  <= (64'(ram_q) << gkcg_pkg::COEF_FRAC_BITS) +
                                64'(total_reg >> 1);
                    rem_reg  <= '0;
                    dvsr_reg <= 32'(total_reg);
                    cnt_reg  <= 7'd64;
                    state_reg <= S_CDIV;
                end
                S_CDIV: begin
                    if (cnt_reg != 0) begin
                        cnt_reg <= cnt_reg - 7'd1;
                        if (!rem_sub[64]) begin
                            rem_reg <= rem_sub[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                    end else begin
                        state_reg <= S_CSAT;
                    end
                end
                S_CSAT: begin
                    coef_reg <= (total_reg == '0) ? '0 :
                                (quo_reg > 64'(gkcg_pkg::COEF_MAX)) ? gkcg_pkg::COEF_MAX :
                                quo_reg[16:0];
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_total_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CDIV) |-> (dvsr_reg != 32'd0))
        else $error("zero normalizing divisor");
    a_term_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TMUL || state_reg == S_TDIV) |-> (k_reg >= 3'd1 && k_reg <= 3'd5))
        else $error("series term index out of range");
    a_sq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQR) |-> (sq_reg <= 4'd7))
        else $error("square count overrun");
`endif

endmodule

// ----- rtl/core/gkcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// gkcg_ctrl
// Sequencer: one pass computing raw weights, one pass emitting coefficients.
// ----------------------------------------------------------------------------
module gkcg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gkcg_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gkcg_pkg::out_item_t   m_data,
    output gkcg_pkg::dp_cmd_t     cmd,
    input  gkcg_pkg::dp_status_t  status,
    input  logic [gkcg_pkg::COEF_W-1:0] coef
);

    typedef enum logic [2:0] {
        C_IDLE, C_CLR, C_TAP, C_TWAIT, C_COEF, C_CWAIT, C_OUT
    } ctrl_state_t;

    ctrl_state_t state_reg;
    logic [gkcg_pkg::TAP_W-1:0] size_reg;
    logic [gkcg_pkg::TAP_W-1:0] idx_reg;
    logic [gkcg_pkg::TAP_W-1:0] reach_next;
    logic [gkcg_pkg::TAP_W-1:0] sz_in;
    logic                       issued_reg;

    assign sz_in = (s_data.tap_count > 6'(gkcg_pkg::MAX_TAPS)) ?
                   6'(gkcg_pkg::MAX_TAPS) : s_data.tap_count;
    assign reach_next = (sz_in - 6'd1) >> 1;
    assign s_ready = (state_reg == C_IDLE);
    assign m_valid = (state_reg == C_OUT);

    always_comb begin
        cmd = '{op: gkcg_pkg::OP_NONE, tap: idx_reg, zero_tap: 1'b0};
        unique case (state_reg)
            C_IDLE: if (s_valid) cmd = '{op: gkcg_pkg::OP_LOAD, tap: reach_next, zero_tap: 1'b0};
            C_CLR: cmd.op = gkcg_pkg::OP_CLEAR_TOTAL;
            C_TAP: begin
                cmd.op = gkcg_pkg::OP_TAP_START;
                cmd.zero_tap = (idx_reg == size_reg - 6'd1) && !size_reg[0];
            end
            C_COEF: cmd.op = gkcg_pkg::OP_COEF_START;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            issued_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                C_IDLE: if (s_valid) begin
                    size_reg <= sz_in;
                    idx_reg  <= '0;
                    state_reg <= (sz_in == '0) ? C_IDLE : C_CLR;
                end
                C_CLR: state_reg <= C_TAP;
                C_TAP: state_reg <= C_TWAIT;
                C_TWAIT: if (!status.busy) begin
                    if (idx_reg == size_reg - 6'd1) begin
                        idx_reg <= '0;
                        state_reg <= C_COEF;
                    end else begin
                        idx_reg <= idx_reg + 6'd1;
                        state_reg <= C_TAP;
                    end
                end
                C_COEF: state_reg <= C_CWAIT;
                C_CWAIT: if (!status.busy) begin
                    m_data <= '{tap_index: idx_reg, coefficient: coef,
                                last_tap: (idx_reg == size_reg - 6'd1)};
                    state_reg <= C_OUT;
                end
                C_OUT: if (m_ready) begin
                    if (m_data.last_tap) begin
                        state_reg <= C_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 6'd1;
                        state_reg <= C_COEF;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
            issued_reg <= (state_reg == C_TAP);
        end
    end

`ifndef SYNTHESIS
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_OUT) |-> (idx_reg < size_reg))
        else $error("tap index past kernel size");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        issued_reg |-> status.busy)
        else $error("datapath ignored tap command");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("accepting during output");
`endif

endmodule

// ----- tb/gaussian_kernel_coefficient_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_kernel_coefficient_generator_tb
// Sends kernel requests under random sender gaps and receiver stalls and
// compares every emitted tap against a fixed-point gaussian predictor.
// ----------------------------------------------------------------------------
module gaussian_kernel_coefficient_generator_tb;

    localparam int WATCHDOG_LIMIT = 200000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    gkcg_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    gkcg_pkg::out_item_t m_data;

    gkcg_pkg::out_item_t tap_queue[$];
    int        mismatch_count;
    int        orphan_count;
    int        idle_cycles;
    bit        hold_off_req;
    bit        stall_enable;

    gaussian_kernel_coefficient_generator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exp(-a), a in Q16, result in Q1.16
    function automatic logic [31:0] gauss_exp(logic [63:0] a);
        logic [63:0]  y;
        logic [63:0]  e;
        logic [63:0]  t;
        logic [127:0] p;
        if (a == 0) return 32'd65536;
        if (a >= 64'(gkcg_pkg::EXP_CUTOFF)) return 32'd0;
        y = a << 8;
        e = 64'd1 << 32;
        t = 64'd1 << 32;
        for (int k = 1; k <= 5; k++) begin
            p = 128'(t) * 128'(y);
            t = 64'(p >> 32) / 64'(k);
            if (k % 2 == 1) e = e - t;
            else e = e + t;
        end
        for (int k = 0; k < 8; k++) begin
            p = 128'(e) * 128'(e) + (128'd1 << 31);
            e = 64'(p >> 32);
        end
        return 32'((e + 64'd32768) >> 16);
    endfunction

    // builds the expected taps of one kernel request
    task automatic predict_kernel(gkcg_pkg::in_item_t req);
        int unsigned      size;
        logic [63:0]      s;
        logic [63:0]      d;
        logic [63:0]      a;
        int unsigned      reach;
        logic [16:0]      raw_weight[gkcg_pkg::MAX_TAPS];
        logic [22:0]      total;
        logic [63:0]      num;
        logic [63:0]      c;
        gkcg_pkg::out_item_t tap;
        size = req.tap_count;
        if (size == 0) return;
        if (size > gkcg_pkg::MAX_TAPS) size = gkcg_pkg::MAX_TAPS;
        s = (req.sigma == 0) ? 64'd1 : 64'(req.sigma);
        reach = (size - 1) / 2;
        total = '0;
        for (int unsigned i = 0; i < size; i++) begin
            raw_weight[i] = '0;
            if (i <= 2 * reach) begin
                d = (i >= reach) ? 64'(i - reach) : 64'(reach - i);
                a = ((d * d) << 31) / (s * s);
                raw_weight[i] = 17'(gauss_exp(a));
            end
            total = total + 23'(raw_weight[i]);
        end
        for (int unsigned i = 0; i < size; i++) begin
            num = (64'(raw_weight[i]) << gkcg_pkg::COEF_FRAC_BITS) + 64'(total >> 1);
            c = (total != 0) ? num / 64'(total) : 64'd0;
            if (c > 64'(gkcg_pkg::COEF_MAX)) c = 64'(gkcg_pkg::COEF_MAX);
            tap.tap_index   = i[gkcg_pkg::TAP_W-1:0];
            tap.coefficient = c[gkcg_pkg::COEF_W-1:0];
            tap.last_tap    = (i == size - 1);
            tap_queue.push_back(tap);
        end
    endtask

    task automatic send_request(logic [5:0] size, logic [15:0] sigma);
        gkcg_pkg::in_item_t req;
        req.tap_count = size;
        req.sigma     = sigma;
        s_data  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_kernel(req);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (tap_queue.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_request(6'd1, 16'd256);
        send_request(6'd63, 16'hFFFF);
        send_request(6'd63, 16'd0);
        send_request(6'd3, 16'd0);
        send_request(6'd0, 16'd512);
        send_request(6'd2, 16'd256);
        send_request(6'd4, 16'd128);
        send_request(6'd62, 16'd2048);
        send_request(6'd5, 16'd1);
        send_request(6'd7, 16'd256);
        send_request(6'd9, 16'h8000);
        send_request(6'd11, 16'h5555);
        send_request(6'd13, 16'hAAAA);
        send_request(6'd21, 16'd300);
        send_request(6'd42, 16'd1000);
        send_request(6'd3, 16'd64);
        send_request(6'd0, 16'd0);
        send_request(6'd15, 16'h00FF);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [5:0]  size;
        logic [15:0] sigma;
        for (int n = 0; n < count; n++) begin
            // mostly small kernels, a few of the largest
            case ($urandom_range(0, 9))
                0:       size = 6'($urandom_range(32, 63));
                1:       size = 6'($urandom_range(0, 63));
                default: size = 6'($urandom_range(1, 9));
            endcase
            case ($urandom_range(0, 3))
                0:       sigma = 16'($urandom);
                1:       sigma = 16'($urandom_range(0, 64));
                default: sigma = 16'($urandom_range(64, 2048));
            endcase
            send_request(size, sigma);
            random_gap();
        end
        wait_drained();
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int n = 0; n < 6; n++) send_request(6'($urandom_range(3, 9)), 16'd256);
        wait (hold_off_req == 1'b0);
        wait_drained();
    endtask

    // receiver stall pattern
    initial begin
        int phase;
        m_ready = 1'b0;
        phase   = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (!stall_enable) begin
                m_ready <= 1'b1;
            end else begin
                phase = (phase + 1) % 64;
                m_ready <= (phase < 32) ? 1'b1 : (($urandom_range(0, 2) != 0) ? 1'b1 : 1'b0);
            end
        end
    end

    // result checker
    initial begin
        gkcg_pkg::out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (tap_queue.size() == 0) begin
                    orphan_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("unexpected transaction: tap %0d coef %0d last %0d",
                                 m_data.tap_index, m_data.coefficient, m_data.last_tap);
                end else begin
                    want = tap_queue.pop_front();
                    if (m_data !== want) begin
                        mismatch_count++;
                        if (mismatch_count + orphan_count <= 10)
                            $display("mismatch: exp tap %0d coef %0d last %0d, got %0d %0d %0d",
                                     want.tap_index, want.coefficient, want.last_tap,
                                     m_data.tap_index, m_data.coefficient, m_data.last_tap);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        mismatch_count = 0;
        orphan_count   = 0;
        hold_off_req   = 1'b0;
        stall_enable   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        stall_enable = 1'b1;
        test_backpressure();
        test_random(340);
        repeat (2000) @(negedge aclk);
        if (mismatch_count == 0 && orphan_count == 0 && tap_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/gkcg_pkg.sv
rtl/core/gkcg_ram.sv
rtl/core/gkcg_datapath.sv
rtl/core/gkcg_ctrl.sv
rtl/core/gaussian_kernel_coefficient_generator.sv
tb/gaussian_kernel_coefficient_generator_tb.sv
